>>> rtl/yuyv_pkg.sv
// package for the yuyv to rgb565 converter: payload types, chroma tables, clamp
package yuyv_pkg;

  localparam int unsigned CoefRv      = 32'd1370705;
  localparam int unsigned CoefBu      = 32'd1732446;
  localparam int unsigned CoefGu      = 32'd337633;
  localparam int unsigned CoefGv      = 32'd698001;
  localparam int unsigned CoefOne     = 32'd1000000;
  localparam int          ChromaBias  = 128;
  localparam int          TableDepth  = 256;
  localparam int          TermW       = 9;
  localparam int          SumW        = 10;
  localparam int          ChanMax     = 255;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
    logic       last_group;
  } yuyv_group_t;

  typedef struct packed {
    logic [15:0] pixel_first;
    logic [15:0] pixel_second;
    logic        last_pair;
  } rgb_pair_t;

  typedef logic signed [TermW-1:0] term_t;
  typedef logic signed [SumW-1:0]  sum_t;
  typedef term_t term_tab_t [TableDepth];

  // trunc(coef * (i - 128) / 1e6) for every chroma byte, built at elaboration
  function automatic term_tab_t build_tab(input int unsigned coef);
    term_tab_t   tab;
    int          d;
    int unsigned mag;
    int unsigned q;
    for (int i = 0; i < TableDepth; i++) begin
      d   = i - ChromaBias;
      mag = (d < 0) ? int'(-d) : int'(d);
      q   = (coef * mag) / CoefOne;
      tab[i] = (d < 0) ? -TermW'(q) : TermW'(q);
    end
    return tab;
  endfunction

  localparam term_tab_t RvTab = build_tab(CoefRv);
  localparam term_tab_t BuTab = build_tab(CoefBu);
  localparam term_tab_t GuTab = build_tab(CoefGu);
  localparam term_tab_t GvTab = build_tab(CoefGv);

  function automatic logic [7:0] clamp_chan(input sum_t v);
    logic [7:0] c;
    if (v < 0) begin
      c = 8'd0;
    end else if (v > SumW'(ChanMax)) begin
      c = 8'(ChanMax);
    end else begin
      c = v[7:0];
    end
    return c;
  endfunction

endpackage

>>> rtl/yuyv_to_rgb565_converter.sv
// top level of the yuyv 4:2:2 to rgb565 converter, three-stage pipeline
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------
//  group in | start / busy        | grp_i  (yuyv_group_t)
//  pair out | valid_o (strobe)    | pair_o (rgb_pair_t)
//
//  one group enters every cycle; each pair comes out once its transaction has
//  passed table lookup, channel sums, clamp and pack, one registered stage each.
//  busy stays low, since the pipeline never has to hold anything back.
//  reset clears only the valid bits of the stages.
module yuyv_to_rgb565_converter
  import yuyv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  yuyv_group_t grp_i,
  output logic        valid_o,
  output rgb_pair_t   pair_o
);

  logic  v1_q, v2_q, v3_q;
  term_t rv_q, bu_q, gu_q, gv_q;
  logic [7:0] y0_q, y1_q;
  logic  last1_q, last2_q;
  sum_t  r0_q, g0_q, b0_q, r1_q, g1_q, b1_q;
  sum_t  r0_d, g0_d, b0_d, r1_d, g1_d, b1_d;
  sum_t  gsum;
  rgb_pair_t pair_q, pair_d;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start & ~busy;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // stage 1: chroma table lookup
  always_ff @(posedge clk_i) begin
    rv_q    <= RvTab[grp_i.chroma_red];
    gv_q    <= GvTab[grp_i.chroma_red];
    bu_q    <= BuTab[grp_i.chroma_blue];
    gu_q    <= GuTab[grp_i.chroma_blue];
    y0_q    <= grp_i.luma_first;
    y1_q    <= grp_i.luma_second;
    last1_q <= grp_i.last_group;
  end

  // stage 2: channel sums
  always_comb begin
    gsum = SumW'(gu_q) + SumW'(gv_q);
    r0_d = sum_t'({2'b00, y0_q}) + SumW'(rv_q);
    g0_d = sum_t'({2'b00, y0_q}) - gsum;
    b0_d = sum_t'({2'b00, y0_q}) + SumW'(bu_q);
    r1_d = sum_t'({2'b00, y1_q}) + SumW'(rv_q);
    g1_d = sum_t'({2'b00, y1_q}) - gsum;
    b1_d = sum_t'({2'b00, y1_q}) + SumW'(bu_q);
  end

  always_ff @(posedge clk_i) begin
    r0_q    <= r0_d;
    g0_q    <= g0_d;
    b0_q    <= b0_d;
    r1_q    <= r1_d;
    g1_q    <= g1_d;
    b1_q    <= b1_d;
    last2_q <= last1_q;
  end

  // stage 3: clamp and pack
  always_comb begin
    logic [7:0] r0, g0, b0, r1, g1, b1;
    r0 = clamp_chan(r0_q);
    g0 = clamp_chan(g0_q);
    b0 = clamp_chan(b0_q);
    r1 = clamp_chan(r1_q);
    g1 = clamp_chan(g1_q);
    b1 = clamp_chan(b1_q);
    pair_d.pixel_first  = {r0[7:3], g0[7:2], b0[7:3]};
    pair_d.pixel_second = {r1[7:3], g1[7:2], b1[7:3]};
    pair_d.last_pair    = last2_q;
  end

  always_ff @(posedge clk_i) begin
    pair_q <= pair_d;
  end

  assign valid_o = v3_q;
  assign pair_o  = pair_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 valid_o)
    else $error("accepted transaction did not produce a pair");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(v2_q))
    else $error("pair strobe without a transaction in stage 2");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 (pair_o.last_pair == $past(grp_i.last_group, 3)))
    else $error("last flag lost in pipeline");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> !busy)
    else $error("pipeline stalled its input");

endmodule

>>> tb/tb_top.sv
// testbench for the yuyv to rgb565 converter: directed and random groups against a predictor
module tb_top;
  import yuyv_pkg::*;

  localparam int HalfPeriod  = 6;
  localparam int ResetCycles = 7;
  localparam int MaxGap      = 13;
  localparam int TailCycles  = 10;
  localparam int CycleLimit  = 200000;
  localparam int RandomItems = 1400;

  localparam longint unsigned KRv  = 64'd1370705;
  localparam longint unsigned KBu  = 64'd1732446;
  localparam longint unsigned KGu  = 64'd337633;
  localparam longint unsigned KGv  = 64'd698001;
  localparam longint unsigned KOne = 64'd1000000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  yuyv_group_t grp_i;
  logic        valid_o;
  rgb_pair_t   pair_o;

  rgb_pair_t pending_pairs [$];
  int        mismatch_count;
  int        cycle_count;
  bit        gaps_on;

  yuyv_to_rgb565_converter uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .grp_i   (grp_i),
    .valid_o (valid_o),
    .pair_o  (pair_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #HalfPeriod clk_i = ~clk_i;
  end

  // signed chroma term, truncated toward zero
  function automatic int chroma_term(input longint unsigned k, input logic [7:0] c);
    int              d;
    longint unsigned mag;
    int              q;
    d   = int'(c) - 128;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    q   = int'((k * mag) / KOne);
    return (d < 0) ? -q : q;
  endfunction

  function automatic logic [7:0] sat_channel(input int v);
    logic [7:0] c;
    if (v < 0) begin
      c = 8'd0;
    end else if (v > 255) begin
      c = 8'd255;
    end else begin
      c = v[7:0];
    end
    return c;
  endfunction

  function automatic logic [15:0] pack_rgb565(input int y, input int rv, input int gs,
                                              input int bu);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = sat_channel(y + rv);
    g = sat_channel(y - gs);
    b = sat_channel(y + bu);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic rgb_pair_t predict_pair(input yuyv_group_t g);
    rgb_pair_t p;
    int        rv;
    int        bu;
    int        gs;
    rv = chroma_term(KRv, g.chroma_red);
    bu = chroma_term(KBu, g.chroma_blue);
    gs = chroma_term(KGu, g.chroma_blue) + chroma_term(KGv, g.chroma_red);
    p.pixel_first  = pack_rgb565(int'(g.luma_first), rv, gs, bu);
    p.pixel_second = pack_rgb565(int'(g.luma_second), rv, gs, bu);
    p.last_pair    = g.last_group;
    return p;
  endfunction

  function automatic logic [7:0] rand_byte();
    logic [7:0] v;
    case ($urandom_range(0, 9))
      0: v = 8'd0;
      1: v = 8'd255;
      2: v = 8'd128;
      3: v = 8'($urandom_range(120, 136));
      default: v = 8'($urandom);
    endcase
    return v;
  endfunction

  function automatic yuyv_group_t rand_group();
    yuyv_group_t g;
    g.luma_first  = rand_byte();
    g.chroma_blue = rand_byte();
    g.luma_second = rand_byte();
    g.chroma_red  = rand_byte();
    g.last_group  = ($urandom_range(0, 7) == 0);
    return g;
  endfunction

  // one transaction; start is touched at most once per falling edge
  task automatic send_group(input yuyv_group_t g);
    int gap;
    gap = gaps_on ? $urandom_range(0, MaxGap) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
      grp_i <= yuyv_group_t'({$urandom, 1'b0});
    end
    @(negedge clk_i);
    start <= 1'b1;
    grp_i <= g;
    do @(posedge clk_i); while (busy);
    pending_pairs.push_back(predict_pair(g));
  endtask

  task automatic send_fields(input logic [7:0] y0, input logic [7:0] u, input logic [7:0] y1,
                             input logic [7:0] v, input logic last);
    yuyv_group_t g;
    g.luma_first  = y0;
    g.chroma_blue = u;
    g.luma_second = y1;
    g.chroma_red  = v;
    g.last_group  = last;
    send_group(g);
  endtask

  task automatic test_field_extremes();
    gaps_on = 1'b0;
    send_fields(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    send_fields(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    send_fields(8'd0, 8'd128, 8'd255, 8'd128, 1'b0);
    send_fields(8'd255, 8'd128, 8'd0, 8'd128, 1'b1);
    send_fields(8'd128, 8'd127, 8'd128, 8'd129, 1'b0);
    send_fields(8'd128, 8'd129, 8'd128, 8'd127, 1'b0);
    send_fields(8'hAA, 8'h55, 8'h55, 8'hAA, 1'b1);
    send_fields(8'h55, 8'hAA, 8'hAA, 8'h55, 1'b0);
  endtask

  task automatic test_channel_saturation();
    gaps_on = 1'b1;
    // red below zero and above 255
    send_fields(8'd0, 8'd128, 8'd10, 8'd0, 1'b0);
    send_fields(8'd255, 8'd128, 8'd200, 8'd255, 1'b0);
    // blue below zero and above 255
    send_fields(8'd0, 8'd0, 8'd100, 8'd128, 1'b0);
    send_fields(8'd255, 8'd255, 8'd60, 8'd128, 1'b1);
    // green below zero and above 255
    send_fields(8'd0, 8'd255, 8'd20, 8'd255, 1'b0);
    send_fields(8'd255, 8'd0, 8'd240, 8'd0, 1'b0);
    // all channels near the edges
    send_fields(8'd1, 8'd1, 8'd254, 8'd254, 1'b1);
    send_fields(8'd254, 8'd254, 8'd1, 8'd1, 1'b0);
  endtask

  task automatic test_random_groups(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) begin
        gaps_on = ($urandom_range(0, 3) != 0);
      end
      send_group(rand_group());
    end
  endtask

  task automatic drain_pairs();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_pairs.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    rgb_pair_t want;
    if (rst_ni && valid_o) begin
      if (pending_pairs.size() == 0) begin
        $error("pair_o: result with no pending transaction, got %h", pair_o);
        mismatch_count++;
      end else begin
        want = pending_pairs.pop_front();
        if (pair_o.pixel_first !== want.pixel_first) begin
          $error("pixel_first: expected %h, got %h", want.pixel_first, pair_o.pixel_first);
          mismatch_count++;
        end
        if (pair_o.pixel_second !== want.pixel_second) begin
          $error("pixel_second: expected %h, got %h", want.pixel_second, pair_o.pixel_second);
          mismatch_count++;
        end
        if (pair_o.last_pair !== want.last_pair) begin
          $error("last_pair: expected %b, got %b", want.last_pair, pair_o.last_pair);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    mismatch_count = 0;
    cycle_count    = 0;
    gaps_on        = 1'b0;
    rst_ni         = 1'b0;
    start          = 1'b0;
    grp_i          = '0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_field_extremes();
    test_channel_saturation();
    test_random_groups(RandomItems);
    drain_pairs();

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/yuyv_pkg.sv
rtl/yuyv_to_rgb565_converter.sv
tb/tb_top.sv
